// ----- src/hwtc_pkg.sv -----
// ----------------------------------------------------------------------------
// hwtc_pkg
// Shared types, codes and helpers of the hashed write-back tier cache.
// ----------------------------------------------------------------------------
`default_nettype none

package hwtc_pkg;

  localparam int DEF_WAYS     = 4;
  localparam int DEF_MAX_BINS = 1024;

  localparam int BLK_W   = 64;
  localparam int TAG_W   = 64;
  localparam int STAMP_W = 64;
  localparam int BINS_W  = 11;
  localparam int LINE_W  = 12;
  localparam int SEED_W  = 32;

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_C3 = 32'h85ebca6b;
  localparam logic [31:0] MM_C4 = 32'hc2b2ae35;
  localparam logic [31:0] MM_N  = 32'he6546b64;
  localparam logic [31:0] MM_M5 = 32'd5;
  localparam logic [31:0] MM_LEN = 32'd4;

  localparam logic REG_SEED = 1'b0;
  localparam logic REG_BINS = 1'b1;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_COPY  = 2'd2,
    CMD_FILL  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_DIV,
    ST_RD,
    ST_CHK,
    ST_UPD,
    ST_WB,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [BLK_W-1:0]   home;
    logic [STAMP_W-1:0] stamp;
    logic               dirty;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [31:0] word;
    logic [31:0] seed;
  } hash_req_t;

  function automatic logic [31:0] bswap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

`default_nettype wire

// ----- src/hwtc_hash.sv -----
// ----------------------------------------------------------------------------
// hwtc_hash
// Multi-cycle 32-bit multiply-rotate hash of one big-endian 32-bit word,
// one multiply a step.
// ----------------------------------------------------------------------------
`default_nettype none

module hwtc_hash
  import hwtc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire hash_req_t   req,
  output logic             done,
  output logic [31:0]      hash
);

  logic [2:0]  step;
  logic        busy;
  logic [31:0] x;
  logic [31:0] seed;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [31:0] madd;
  logic [63:0] prod;
  logic [31:0] t;

  always_comb begin
    t    = x ^ MM_LEN;
    t    = t ^ (t >> 16);
    ma   = x;
    mb   = MM_C1;
    madd = '0;
    unique case (step)
      3'd0: begin
        ma = x;
        mb = MM_C1;
      end
      3'd1: begin
        ma = rotl32(x, 15);
        mb = MM_C2;
      end
      3'd2: begin
        ma   = rotl32(seed ^ x, 13);
        mb   = MM_M5;
        madd = MM_N;
      end
      3'd3: begin
        ma = t;
        mb = MM_C3;
      end
      3'd4: begin
        ma = x ^ (x >> 13);
        mb = MM_C4;
      end
      default: begin
        ma = x;
        mb = MM_C1;
      end
    endcase
    prod = 64'(ma) * 64'(mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x    <= bswap32(req.word);
      seed <= req.seed;
    end else if (busy) begin
      if (step == 3'd5) begin
        hash <= x ^ (x >> 16);
      end else begin
        x <= prod[31:0] + madd;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/hashed_writeback_tier_cache_controller.sv -----
// ----------------------------------------------------------------------------
// hashed_writeback_tier_cache_controller
// Set-associative write-back tier cache directory with hashed tags and LRU.
//
//   channel   dir   handshake          payload
//   request   in    in_valid/in_stall  kind, block_number
//   command   out   out_valid/out_stall command, fast_line, slow_block,
//                                      was_hit, last_command
//   config    in    APB                hash_seed @0, bin_count @4
//
// One request at a time: accept, hash, a bit-serial remainder over the tag,
// a read and a check per way searched up to the first tag match, an update,
// then the command, preceded by a copy command when there is a write-back.
// After reset a clearing pass writes MAX_BINS*WAYS metadata entries, one a
// cycle, with in_stall high; configuration writes are taken meanwhile.
// out_stall holds the pending command; the sequencer waits only when it has a new command to load.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_writeback_tier_cache_controller
  import hwtc_pkg::*;
#(
  parameter int WAYS     = DEF_WAYS,
  parameter int MAX_BINS = DEF_MAX_BINS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              kind,
  input  wire logic [BLK_W-1:0]  block_number,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             command,
  output logic [LINE_W-1:0]      fast_line,
  output logic [BLK_W-1:0]       slow_block,
  output logic                   was_hit,
  output logic                   last_command
);

  localparam int DEPTH = MAX_BINS * WAYS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;

  state_t state, state_next;

  logic [SEED_W-1:0] hash_seed;
  logic [BINS_W-1:0] bin_count;

  logic [AW-1:0]      clr_cnt;
  logic               kind_r;
  logic [BLK_W-1:0]   blk_r;
  logic [STAMP_W-1:0] access_clock;
  logic [TAG_W-1:0]   quo;
  logic [BINS_W-1:0]  rem;
  logic [BINS_W-1:0]  bins_r;
  logic [5:0]         div_cnt;
  logic [WW-1:0]      way;
  logic [WW-1:0]      vict_way;
  logic [BLK_W-1:0]   vict_home;
  logic               vict_dirty;
  logic [STAMP_W-1:0] oldest;
  logic               hit_r;

  entry_t mem [DEPTH];
  entry_t rdata;
  entry_t wdata;
  logic   mem_we;
  logic   mem_re;
  logic [AW-1:0] mem_addr;

  hash_req_t   hreq_hi, hreq_lo;
  logic        hdone_hi, hdone_lo;
  logic [31:0] hash_hi, hash_lo;

  logic        accept;
  logic        can_load;
  logic        out_load;
  logic        tag_match;
  logic [BINS_W:0]  rem_shift;
  logic [BINS_W-1:0] bins_eff;
  logic [31:0] line_rd;
  logic [31:0] line_vict;

  assign pready   = 1'b1;
  assign accept   = in_valid && !in_stall;
  assign can_load = !out_valid || !out_stall;
  assign tag_match = (rdata.tag == quo);
  assign line_rd   = 32'(rem) * 32'(WAYS) + 32'(way);
  assign line_vict = 32'(rem) * 32'(WAYS) + 32'(vict_way);

  always_comb begin
    priority if (bin_count == '0) begin
      bins_eff = BINS_W'(1);
    end else if (32'(bin_count) > 32'(MAX_BINS)) begin
      bins_eff = BINS_W'(MAX_BINS);
    end else begin
      bins_eff = bin_count;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= '0;
      bin_count <= BINS_W'(DEF_MAX_BINS);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_SEED: hash_seed <= pwdata;
        REG_BINS: bin_count <= pwdata[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SEED: prdata = hash_seed;
      REG_BINS: prdata = 32'(bin_count);
      default:  prdata = '0;
    endcase
  end

  assign hreq_hi = '{start: accept, word: block_number[63:32], seed: hash_seed};
  assign hreq_lo = '{start: accept, word: block_number[31:0], seed: hash_seed};

  hwtc_hash u_hash_hi (
    .clk  (clk),
    .rst  (rst),
    .req  (hreq_hi),
    .done (hdone_hi),
    .hash (hash_hi)
  );

  hwtc_hash u_hash_lo (
    .clk  (clk),
    .rst  (rst),
    .req  (hreq_lo),
    .done (hdone_lo),
    .hash (hash_lo)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == AW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_HASH;
      ST_HASH:  if (hdone_hi && hdone_lo) state_next = ST_DIV;
      ST_DIV:   if (div_cnt == 6'd63) state_next = ST_RD;
      ST_RD:    state_next = ST_CHK;
      ST_CHK: begin
        if (tag_match || way == WW'(WAYS - 1)) state_next = ST_UPD;
        else state_next = ST_RD;
      end
      ST_UPD:   state_next = (!hit_r && vict_dirty) ? ST_WB : ST_FILL;
      ST_WB:    if (can_load) state_next = ST_FILL;
      ST_FILL:  if (can_load) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = (state != ST_IDLE);
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = line_rd[AW-1:0];
    wdata    = '0;
    out_load = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
      end
      ST_RD: mem_re = 1'b1;
      ST_UPD: begin
        mem_we      = 1'b1;
        mem_addr    = line_vict[AW-1:0];
        wdata.tag   = quo;
        wdata.home  = blk_r;
        wdata.stamp = access_clock;
        wdata.dirty = hit_r ? (vict_dirty | kind_r) : kind_r;
      end
      ST_WB, ST_FILL: out_load = can_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= wdata;
    if (mem_re) rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      access_clock <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (accept) access_clock <= access_clock + STAMP_W'(1);
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  assign rem_shift = {rem, quo[TAG_W-1]};

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          kind_r <= kind;
          blk_r  <= block_number;
          bins_r <= bins_eff;
        end
      end
      ST_HASH: begin
        quo     <= {hash_hi, hash_lo};
        rem     <= '0;
        div_cnt <= '0;
        way     <= '0;
        hit_r   <= 1'b0;
      end
      ST_DIV: begin
        div_cnt <= div_cnt + 6'd1;
        quo     <= {quo[TAG_W-2:0], quo[TAG_W-1]};
        if (rem_shift >= {1'b0, bins_r}) rem <= BINS_W'(rem_shift - {1'b0, bins_r});
        else rem <= rem_shift[BINS_W-1:0];
      end
      ST_CHK: begin
        way <= way + WW'(1);
        if (tag_match) begin
          vict_way   <= way;
          vict_home  <= rdata.home;
          vict_dirty <= rdata.dirty;
          hit_r      <= (rdata.home == blk_r);
        end else if (way == '0 || rdata.stamp < oldest) begin
          oldest     <= rdata.stamp;
          vict_way   <= way;
          vict_home  <= rdata.home;
          vict_dirty <= rdata.dirty;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      fast_line <= line_vict[LINE_W-1:0];
      if (state == ST_WB) begin
        command      <= CMD_COPY;
        slow_block   <= vict_home;
        was_hit      <= 1'b0;
        last_command <= 1'b0;
      end else begin
        command      <= kind_r ? CMD_WRITE : (hit_r ? CMD_READ : CMD_FILL);
        slow_block   <= blk_r;
        was_hit      <= hit_r;
        last_command <= 1'b1;
      end
    end
  end

  a_first_is_copy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_command |-> command == CMD_COPY)
    else $error("non-final command is not a copy");

  a_hit_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_hit |-> last_command)
    else $error("hit produced a write-back");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD |-> rem < bins_r)
    else $error("bin index out of range");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hashed write-back tier cache controller.
// Requests go in with random gaps and command stalls. A behavioral copy of
// the directory (murmur tags, bins, LRU ways, dirty bits) predicts every
// command; each is compared with it or a listed one. Several seed and bin
// count settings are applied between phases, the extremes among them.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import hwtc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NWAYS   = DEF_WAYS;
  localparam int NLINES  = DEF_MAX_BINS * DEF_WAYS;
  localparam int WDOG    = 20000;
  localparam int NPHASES = 6;
  localparam int PER_PHASE = 260;

  typedef struct packed {
    cmd_t              cmd;
    logic [LINE_W-1:0] line;
    logic [BLK_W-1:0]  slow;
    logic              hit;
    logic              last;
  } mover_cmd_t;

  typedef struct {
    logic             wr;
    logic [BLK_W-1:0] blk;
    logic             typed;
    cmd_t             cmd;
    int               line;
    logic             hit;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [BLK_W-1:0] block_number = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] command;
  logic [LINE_W-1:0] fast_line;
  logic [BLK_W-1:0] slow_block;
  logic was_hit;
  logic last_command;

  logic [TAG_W-1:0]   tag_mem [NLINES];
  logic [BLK_W-1:0]   home_mem [NLINES];
  logic [STAMP_W-1:0] use_mem [NLINES];
  logic               dirty_mem [NLINES];
  logic [STAMP_W-1:0] use_count;
  logic [31:0]        seed_reg;
  logic [10:0]        bins_reg;

  mover_cmd_t pending_cmds [$];
  mover_cmd_t new_cmds [2];
  int n_new;
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  int out_hold = 0;
  row_t rows [$];

  hashed_writeback_tier_cache_controller dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .kind, .block_number,
    .out_valid, .out_stall, .command, .fast_line, .slow_block, .was_hit,
    .last_command
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rol(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] murmur_be(input logic [31:0] w, input logic [31:0] s);
    logic [31:0] k;
    logic [31:0] h;
    k = {w[7:0], w[15:8], w[23:16], w[31:24]};
    k = k * MM_C1;
    k = rol(k, 15);
    k = k * MM_C2;
    h = s ^ k;
    h = rol(h, 13);
    h = h * MM_M5 + MM_N;
    h = h ^ MM_LEN;
    h = h ^ (h >> 16);
    h = h * MM_C3;
    h = h ^ (h >> 13);
    h = h * MM_C4;
    h = h ^ (h >> 16);
    return h;
  endfunction

  task automatic clear_directory();
    for (int i = 0; i < NLINES; i++) begin
      tag_mem[i] = '0;
      home_mem[i] = '0;
      use_mem[i] = '0;
      dirty_mem[i] = 1'b0;
    end
    use_count = '0;
    seed_reg = '0;
    bins_reg = 11'd1024;
  endtask

  task automatic predict_access(input logic wr, input logic [BLK_W-1:0] blk);
    logic [TAG_W-1:0] tag;
    logic [63:0] nbins;
    logic [63:0] bin;
    logic [STAMP_W-1:0] oldest;
    int base, victim, ln;
    bit tag_match, hit;
    tag = {murmur_be(blk[63:32], seed_reg), murmur_be(blk[31:0], seed_reg)};
    nbins = 64'(bins_reg);
    if (nbins == 0) nbins = 1;
    if (nbins > DEF_MAX_BINS) nbins = DEF_MAX_BINS;
    bin = tag % nbins;
    base = int'(bin) * NWAYS;
    use_count = use_count + 1;
    tag_match = 1'b0;
    hit = 1'b0;
    victim = 0;
    n_new = 0;
    for (int w = 0; w < NWAYS; w++) begin
      if (!tag_match && tag_mem[base + w] == tag) begin
        tag_match = 1'b1;
        victim = w;
        hit = (home_mem[base + w] == blk);
      end
    end
    if (!tag_match) begin
      oldest = use_mem[base];
      for (int w = 1; w < NWAYS; w++) begin
        if (use_mem[base + w] < oldest) begin
          oldest = use_mem[base + w];
          victim = w;
        end
      end
    end
    ln = base + victim;
    if (hit) begin
      use_mem[ln] = use_count;
      if (wr) dirty_mem[ln] = 1'b1;
      new_cmds[0] = '{wr ? CMD_WRITE : CMD_READ, ln[LINE_W-1:0], blk, 1'b1, 1'b1};
      n_new = 1;
    end else begin
      if (dirty_mem[ln]) begin
        new_cmds[0] = '{CMD_COPY, ln[LINE_W-1:0], home_mem[ln], 1'b0, 1'b0};
        n_new = 1;
      end
      tag_mem[ln] = tag;
      home_mem[ln] = blk;
      use_mem[ln] = use_count;
      dirty_mem[ln] = wr;
      new_cmds[n_new] = '{wr ? CMD_WRITE : CMD_FILL, ln[LINE_W-1:0], blk, 1'b0, 1'b1};
      n_new++;
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (idx == REG_SEED) seed_reg = val;
    else bins_reg = val[10:0];
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send_request(input logic wr, input logic [BLK_W-1:0] blk,
                              output logic accepted_wr);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= wr;
    block_number <= blk;
    do @(posedge clk); while (in_stall);
    accepted_wr = wr;
  endtask

  task automatic queue_predicted();
    for (int i = 0; i < n_new; i++) pending_cmds = {pending_cmds, new_cmds[i]};
  endtask

  function automatic logic [BLK_W-1:0] fresh_block();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {32'h0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_hold <= $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    mover_cmd_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        report("unexpected command", 64'(command), 64'd0);
      end else begin
        want = pending_cmds.pop_front();
        if (command != want.cmd) report("command", command, want.cmd);
        if (fast_line != want.line) report("fast_line", fast_line, want.line);
        if (slow_block != want.slow) report("slow_block", slow_block, want.slow);
        if (was_hit != want.hit) report("was_hit", was_hit, want.hit);
        if (last_command != want.last) report("last_command", last_command, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic wr;
    logic [BLK_W-1:0] blk;
    logic [BLK_W-1:0] pool [16];
    row_t r;
    mover_cmd_t typed_cmd;
    clear_directory();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apb_write(REG_BINS, 32'd1);
    apb_write(REG_SEED, 32'd0);
    rows = '{
      '{1'b0, 64'h11, 1'b1, CMD_FILL,  0, 1'b0},
      '{1'b0, 64'h11, 1'b1, CMD_READ,  0, 1'b1},
      '{1'b1, 64'h11, 1'b1, CMD_WRITE, 0, 1'b1},
      '{1'b1, 64'h22, 1'b1, CMD_WRITE, 1, 1'b0},
      '{1'b0, 64'h33, 1'b1, CMD_FILL,  2, 1'b0},
      '{1'b0, 64'h44, 1'b1, CMD_FILL,  3, 1'b0},
      '{1'b0, 64'h55, 1'b0, CMD_READ,  0, 1'b0},
      '{1'b1, 64'h0, 1'b0, CMD_READ, 0, 1'b0},
      '{1'b1, '1, 1'b0, CMD_READ, 0, 1'b0},
      '{1'b0, 64'h8000_0000_0000_0000, 1'b0, CMD_READ, 0, 1'b0},
      '{1'b1, 64'h0000_0000_FFFF_FFFF, 1'b0, CMD_READ, 0, 1'b0},
      '{1'b0, 64'hFFFF_FFFF_0000_0000, 1'b0, CMD_READ, 0, 1'b0},
      '{1'b0, '1, 1'b0, CMD_READ, 0, 1'b0},
      '{1'b1, 64'h0, 1'b0, CMD_READ, 0, 1'b0},
      '{1'b0, 64'h22, 1'b0, CMD_READ, 0, 1'b0},
      '{1'b1, 64'h55, 1'b0, CMD_READ, 0, 1'b0},
      '{1'b0, 64'h0000_0000_0000_0001, 1'b0, CMD_READ, 0, 1'b0},
      '{1'b1, 64'hAAAA_AAAA_5555_5555, 1'b0, CMD_READ, 0, 1'b0}
    };
    foreach (rows[i]) begin
      r = rows[i];
      send_request(r.wr, r.blk, wr);
      predict_access(r.wr, r.blk);
      if (r.typed) begin
        typed_cmd = '{r.cmd, LINE_W'(r.line), r.blk, r.hit, 1'b1};
        pending_cmds = {pending_cmds, typed_cmd};
      end else begin
        queue_predicted();
      end
    end
    in_valid <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < NPHASES; ph++) begin
      case (ph)
        0: begin apb_write(REG_SEED, 32'hFFFF_FFFF); apb_write(REG_BINS, 32'd0); end
        1: begin apb_write(REG_SEED, $urandom()); apb_write(REG_BINS, 32'd2047); end
        2: begin apb_write(REG_SEED, 32'd0); apb_write(REG_BINS, 32'd2); end
        3: begin apb_write(REG_SEED, $urandom()); apb_write(REG_BINS, $urandom_range(3, 40)); end
        4: begin apb_write(REG_SEED, $urandom()); apb_write(REG_BINS, 32'd1024); end
        default: begin
          apb_write(REG_SEED, $urandom()); apb_write(REG_BINS, $urandom_range(1, 2047));
          quiet = 1'b1;
        end
      endcase
      foreach (pool[i]) pool[i] = fresh_block();
      for (int n = 0; n < PER_PHASE; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          blk = pool[$urandom_range(0, 15)];
        end else begin
          blk = fresh_block();
          pool[$urandom_range(0, 15)] = blk;
        end
        send_request(1'($urandom_range(0, 1)), blk, wr);
        predict_access(wr, blk);
        queue_predicted();
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
